FILE: src/sse_event_stream_parser_assert.svh
// Assertion macros for the SSE tokenizer.
// Clocked on clk and disabled while arst_n is low; used by the top level.
`ifndef SSE_EVENT_STREAM_PARSER_ASSERT_SVH
`define SSE_EVENT_STREAM_PARSER_ASSERT_SVH

// same-cycle implication
`define SSE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/sse_pkg.sv
// Shared types, character constants and per-byte line functions of the SSE tokenizer.
// No dependencies; used by sse_step, sse_out_buf and sse_event_stream_parser.
package sse_pkg;

	typedef enum logic [1:0] {
		IK_BYTE = 2'd0,
		IK_EOS  = 2'd1,
		IK_HALT = 2'd2,
		IK_NONE = 2'd3
	} in_kind_t;

	typedef enum logic [2:0] {
		K_CLEAR    = 3'd0,
		K_NAMEB    = 3'd1,
		K_DATAB    = 3'd2,
		K_NEWLINE  = 3'd3,
		K_DISPATCH = 3'd4
	} tok_kind_t;

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_NAME   = 3'd1,
		PH_IGNORE = 3'd2,
		PH_EVENT  = 3'd3,
		PH_DATA   = 3'd4
	} phase_t;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int CAND_EV_BIT = 0;
	localparam int CAND_DA_BIT = 1;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] mcount;
		logic [1:0] cand;
		logic       skip;
		logic       ev_ne;
		logic       da_ne;
	} st_t;

	localparam st_t ST_RESET = '{
		phase: PH_START, mcount: 3'd0, cand: 2'b11, skip: 1'b0, ev_ne: 1'b0, da_ne: 1'b0
	};

	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] data;
	} tok_t;

	typedef struct packed {
		st_t  st;
		logic tv;
		tok_t tok;
	} pb_res_t;

	typedef struct packed {
		st_t        st;
		logic       held;
		logic       halted;
		logic [1:0] n;
		tok_t       t0;
		tok_t       t1;
	} step_out_t;

	function automatic logic [7:0] ev_char(logic [2:0] i);
		logic [7:0] ch;
		unique case (i)
			3'd0: ch = 8'h65; // e
			3'd1: ch = 8'h76; // v
			3'd2: ch = 8'h65; // e
			3'd3: ch = 8'h6E; // n
			3'd4: ch = 8'h74; // t
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] da_char(logic [2:0] i);
		logic [7:0] ch;
		unique case (i)
			3'd0: ch = 8'h64; // d
			3'd1: ch = 8'h61; // a
			3'd2: ch = 8'h74; // t
			3'd3: ch = 8'h61; // a
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_ev_name(st_t s);
		return s.cand[CAND_EV_BIT] && (s.mcount == 3'd5);
	endfunction

	function automatic logic is_da_name(st_t s);
		return s.cand[CAND_DA_BIT] && (s.mcount == 3'd4);
	endfunction

	// one ordinary byte of a line: at most one token
	function automatic pb_res_t plain_byte(st_t s, logic [7:0] c);
		pb_res_t r;
		r.st = s;
		r.tv = 1'b0;
		r.tok.kind = K_CLEAR;
		r.tok.data = 8'h00;
		if (s.phase == PH_START || s.phase == PH_NAME) begin
			r.st.phase = PH_NAME;
			if (c == CH_COLON) begin
				if (is_ev_name(s)) begin
					r.tv = 1'b1;
					r.tok.kind = K_CLEAR;
					r.st.ev_ne = 1'b0;
					r.st.phase = PH_EVENT;
					r.st.skip = 1'b1;
				end else if (is_da_name(s)) begin
					r.tv = s.da_ne;
					r.tok.kind = K_NEWLINE;
					r.st.phase = PH_DATA;
					r.st.skip = 1'b1;
				end else begin
					r.st.phase = PH_IGNORE;
				end
			end else begin
				if (s.mcount >= 3'd5 || ev_char(s.mcount) != c)
					r.st.cand[CAND_EV_BIT] = 1'b0;
				if (s.mcount >= 3'd4 || da_char(s.mcount) != c)
					r.st.cand[CAND_DA_BIT] = 1'b0;
				if (s.mcount != 3'd7)
					r.st.mcount = s.mcount + 3'd1;
			end
		end else if (s.phase == PH_EVENT || s.phase == PH_DATA) begin
			r.st.skip = 1'b0;
			if (!(s.skip && c == CH_SPACE)) begin
				r.tv = 1'b1;
				r.tok.data = c;
				if (s.phase == PH_EVENT) begin
					r.tok.kind = K_NAMEB;
					r.st.ev_ne = 1'b1;
				end else begin
					r.tok.kind = K_DATAB;
					r.st.da_ne = 1'b1;
				end
			end
		end
		return r;
	endfunction

	function automatic pb_res_t dispatch_if_any(st_t s);
		pb_res_t r;
		r.st = s;
		r.tv = s.ev_ne || s.da_ne;
		r.tok.kind = K_DISPATCH;
		r.tok.data = 8'h00;
		r.st.ev_ne = 1'b0;
		r.st.da_ne = 1'b0;
		return r;
	endfunction

	// line end: blank line dispatches, a bare field name acts as if followed by a colon
	function automatic pb_res_t end_line(st_t s);
		pb_res_t r;
		r.st = s;
		r.tv = 1'b0;
		r.tok.kind = K_CLEAR;
		r.tok.data = 8'h00;
		if (s.phase == PH_START) begin
			r = dispatch_if_any(s);
		end else if (s.phase == PH_NAME) begin
			if (is_ev_name(s)) begin
				r.tv = 1'b1;
				r.tok.kind = K_CLEAR;
				r.st.ev_ne = 1'b0;
			end else if (is_da_name(s)) begin
				r.tv = s.da_ne;
				r.tok.kind = K_NEWLINE;
			end
		end
		r.st.phase = PH_START;
		r.st.mcount = 3'd0;
		r.st.cand = 2'b11;
		r.st.skip = 1'b0;
		return r;
	endfunction

endpackage

FILE: src/sse_step.sv
// Next-state and token logic for one input beat of the SSE tokenizer.
// Depends on sse_pkg (types and line functions).
module sse_step (
	input  sse_pkg::st_t      st,
	input  logic              held,
	input  logic              halted,
	input  logic [1:0]        kind,
	input  logic [7:0]        data,
	output sse_pkg::step_out_t res
);

	sse_pkg::pb_res_t r1;
	sse_pkg::pb_res_t r2;
	sse_pkg::st_t     s;
	logic             held_n;
	logic             halted_n;

	always_comb begin
		r1 = '0;
		r2 = '0;
		s = st;
		held_n = held;
		halted_n = halted;
		unique case (kind)
			sse_pkg::IK_BYTE: begin
				if (held) begin
					held_n = 1'b0;
					if (data == sse_pkg::CH_LF) begin
						r1 = sse_pkg::end_line(st);
						s = r1.st;
					end else begin
						// replay the held CR as a plain byte first
						r1 = sse_pkg::plain_byte(st, sse_pkg::CH_CR);
						s = r1.st;
						if (data == sse_pkg::CH_CR) begin
							held_n = 1'b1;
						end else begin
							r2 = sse_pkg::plain_byte(r1.st, data);
							s = r2.st;
						end
					end
				end else if (data == sse_pkg::CH_LF) begin
					r1 = sse_pkg::end_line(st);
					s = r1.st;
				end else if (data == sse_pkg::CH_CR) begin
					held_n = 1'b1;
				end else begin
					r1 = sse_pkg::plain_byte(st, data);
					s = r1.st;
				end
			end
			sse_pkg::IK_EOS: begin
				held_n = 1'b0;
				r1 = sse_pkg::end_line(st);
				r2 = sse_pkg::dispatch_if_any(r1.st);
				s = r2.st;
			end
			sse_pkg::IK_HALT: begin
				halted_n = 1'b1;
			end
			default: begin
			end
		endcase

		res.st = s;
		res.held = held_n;
		res.halted = halted_n;
		// pack tokens towards slot 0; drop all once halted
		if (halted_n)
			res.n = 2'd0;
		else
			res.n = {1'b0, r1.tv} + {1'b0, r2.tv};
		res.t0 = r1.tv ? r1.tok : r2.tok;
		res.t1 = r2.tok;
	end

endmodule

FILE: src/sse_out_buf.sv
// Two-entry result register of the SSE tokenizer: loads up to two tokens, sends one a cycle while out_stall is low.
// Depends on sse_pkg (token type).
module sse_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [1:0]        n,
	input  sse_pkg::tok_t     t0,
	input  sse_pkg::tok_t     t1,
	output logic              ready,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        out_kind,
	output logic [7:0]        out_byte,
	output logic              out_last
);

	logic          v0_q;
	logic          v1_q;
	sse_pkg::tok_t tok0_q;
	sse_pkg::tok_t tok1_q;
	logic          last0_q;
	logic          fire;
	logic          put;

	assign fire  = v0_q && !out_stall;
	assign ready = !v0_q || (!v1_q && fire);
	assign put   = load && (n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (put) begin
			v0_q <= 1'b1;
			v1_q <= (n == 2'd2);
		end else if (fire) begin
			v0_q <= v1_q;
			v1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (put) begin
			tok0_q  <= t0;
			tok1_q  <= t1;
			last0_q <= (n == 2'd1);
		end else if (fire) begin
			// advance the second token; it always closes its beat
			tok0_q  <= tok1_q;
			last0_q <= 1'b1;
		end
	end

	assign out_valid = v0_q;
	assign out_kind  = tok0_q.kind;
	assign out_byte  = tok0_q.data;
	assign out_last  = last0_q;

endmodule

FILE: src/sse_event_stream_parser.sv
// Channel  Direction  Handshake             Payload
// in       sink       in_valid / in_stall   in_kind[1:0], in_byte[7:0]
// out      source     out_valid / out_stall out_kind[2:0], out_byte[7:0], out_last
//
// One input beat is taken per cycle into the input register while in_stall is low;
// its tokens (zero to two) are loaded into the result register once it is ready. A
// beat giving two tokens holds the result register until both are sent, so that single
// register port sets the rate of such beats. Reset (arst_n low) returns
// to line start with empty name and data. in_stall rises only while the input register
// holds a beat that the result register cannot take.
//
// Top level of the SSE tokenizer; depends on sse_pkg, sse_step, sse_out_buf and
// sse_event_stream_parser_assert.svh.
module sse_event_stream_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] in_kind,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] out_kind,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic               valid_s1;
	logic [1:0]         kind_s1;
	logic [7:0]         byte_s1;
	sse_pkg::st_t       st_q;
	logic               held_q;
	logic               halted_q;
	sse_pkg::step_out_t step;
	logic               buf_ready;
	logic               advance;

	assign advance  = valid_s1 && buf_ready;
	assign in_stall = valid_s1 && !buf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= in_kind;
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= sse_pkg::ST_RESET;
			held_q   <= 1'b0;
			halted_q <= 1'b0;
		end else if (advance) begin
			st_q     <= step.st;
			held_q   <= step.held;
			halted_q <= step.halted;
		end
	end

	sse_step u_step (
		.st     (st_q),
		.held   (held_q),
		.halted (halted_q),
		.kind   (kind_s1),
		.data   (byte_s1),
		.res    (step)
	);

	sse_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.n         (step.n),
		.t0        (step.t0),
		.t1        (step.t1),
		.ready     (buf_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

`include "sse_event_stream_parser_assert.svh"

	`SSE_ASSERT_NXT(a_pair_follows, out_valid && !out_last, out_valid, "second token of a beat lost")
	`SSE_ASSERT_IMP(a_halt_silent, halted_q, step.n == 2'd0, "token produced after halt")
	`SSE_ASSERT_IMP(a_stall_held, in_stall, valid_s1, "stall without a held beat")
	`SSE_ASSERT_NXT(a_pair_head, advance && step.n == 2'd2, out_valid && !out_last, "pair not at head")

endmodule
